// ===== design/mmdec_pkg.sv =====
// Shared types, constants and the column_ratio helper function for the min/max waveform decimator.
`timescale 1ns / 1ps
`default_nettype none
package mmdec_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COLUMN_BITS_DEF = 13;
  localparam int QUEUE_DEPTH     = 4;
  localparam int X_BITS          = 14;
  localparam int Y_BITS          = 27;
  localparam int FRAC_BITS       = 16;
  localparam int BOUNDARY_BITS   = 48;
  localparam int CFG_ADDR_BITS   = 5;
  localparam int CFG_DATA_BITS   = 32;

  typedef enum logic [2:0] {
    REG_SAMPLES_PER_COLUMN = 3'd0,
    REG_TOP_LEVEL          = 3'd1,
    REG_LEVEL_OFFSET       = 3'd2,
    REG_PIXELS_PER_CODE    = 3'd3,
    REG_TOP_MARGIN         = 3'd4,
    REG_X_OFFSET           = 3'd5,
    REG_MAX_COLUMNS        = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic        [31:0] samples_per_column;
    logic signed [15:0] top_level;
    logic signed [15:0] level_offset;
    logic        [23:0] pixels_per_code;
    logic        [11:0] top_margin;
    logic signed [12:0] x_offset;
    logic        [12:0] max_columns;
  } cfg_t;

  typedef struct packed {
    logic        write;
    logic [31:0] value;
  } ratio_write_t;

  // Ratios below one sample per column are raised to exactly one.
  function automatic logic [BOUNDARY_BITS-1:0] column_ratio(input logic [31:0] spc);
    logic [31:0] r;
    r = (spc < 32'h0001_0000) ? 32'h0001_0000 : spc;
    return BOUNDARY_BITS'(r);
  endfunction

endpackage
`default_nettype wire

// ===== design/mmdec_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module mmdec_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mmdec_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [mmdec_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic      [mmdec_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                    pready,
  output mmdec_pkg::cfg_t                         cfg,
  output mmdec_pkg::ratio_write_t                 ratio_wr
);
  import mmdec_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[4:2];

  assign ratio_wr.write = wr_en && (idx == REG_SAMPLES_PER_COLUMN);
  assign ratio_wr.value = pwdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_column <= 32'h0001_0000;
      cfg.top_level          <= '0;
      cfg.level_offset       <= '0;
      cfg.pixels_per_code    <= 24'h01_0000;
      cfg.top_margin         <= '0;
      cfg.x_offset           <= '0;
      cfg.max_columns        <= 13'd1024;
    end else if (wr_en) begin
      case (idx)
        REG_SAMPLES_PER_COLUMN: cfg.samples_per_column <= pwdata;
        REG_TOP_LEVEL:          cfg.top_level          <= pwdata[15:0];
        REG_LEVEL_OFFSET:       cfg.level_offset       <= pwdata[15:0];
        REG_PIXELS_PER_CODE:    cfg.pixels_per_code    <= pwdata[23:0];
        REG_TOP_MARGIN:         cfg.top_margin         <= pwdata[11:0];
        REG_X_OFFSET:           cfg.x_offset           <= pwdata[12:0];
        REG_MAX_COLUMNS:        cfg.max_columns        <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SAMPLES_PER_COLUMN: prdata = cfg.samples_per_column;
      REG_TOP_LEVEL:          prdata = {16'd0, cfg.top_level};
      REG_LEVEL_OFFSET:       prdata = {16'd0, cfg.level_offset};
      REG_PIXELS_PER_CODE:    prdata = {8'd0, cfg.pixels_per_code};
      REG_TOP_MARGIN:         prdata = {20'd0, cfg.top_margin};
      REG_X_OFFSET:           prdata = {19'd0, cfg.x_offset};
      REG_MAX_COLUMNS:        prdata = {19'd0, cfg.max_columns};
      default:                prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/mmdec_front.sv =====
// Front end: tracks column boundaries, keeps the open column's samples and queues closed columns.
`timescale 1ns / 1ps
`default_nettype none
module mmdec_front #(
  parameter int SAMPLE_BITS = mmdec_pkg::SAMPLE_BITS_DEF,
  parameter int COLUMN_BITS = mmdec_pkg::COLUMN_BITS_DEF,
  parameter int ENTRY_BITS  = COLUMN_BITS + 4 * SAMPLE_BITS + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mmdec_pkg::cfg_t               cfg,
  input  wire mmdec_pkg::ratio_write_t       ratio_wr,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          last,
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire logic                          queue_full,
  output logic                               push,
  output logic [ENTRY_BITS-1:0]              push_data
);
  import mmdec_pkg::*;

  localparam int CMP_BITS = (COLUMN_BITS > 13) ? COLUMN_BITS + 1 : 14;

  logic [31:0]                   sample_count;
  logic [COLUMN_BITS-1:0]        column_count;
  logic [BOUNDARY_BITS-1:0]      next_boundary;
  logic signed [SAMPLE_BITS-1:0] bin_first, bin_min, bin_max, bin_last;
  logic                          bin_open;
  logic                          pending;
  logic [ENTRY_BITS-1:0]         pending_entry;

  logic                          accept;
  logic                          active_now, active_after, close, emit_eor;
  logic [COLUMN_BITS-1:0]        column_after;
  logic signed [SAMPLE_BITS-1:0] first_next, min_next, max_next;
  logic [ENTRY_BITS-1:0]         closed_entry, eor_entry;

  assign sample_stall = pending | queue_full;
  assign accept       = sample_valid & ~sample_stall;

  always_comb begin
    active_now   = CMP_BITS'(column_count) < CMP_BITS'(cfg.max_columns);
    close        = bin_open && active_now && (sample_count >= next_boundary[47:16]);
    column_after = close ? column_count + 1'b1 : column_count;
    active_after = CMP_BITS'(column_after) < CMP_BITS'(cfg.max_columns);
    emit_eor     = last && active_after;
    if (close || !bin_open) begin
      first_next = sample;
      min_next   = sample;
      max_next   = sample;
    end else begin
      first_next = bin_first;
      min_next   = (sample < bin_min) ? sample : bin_min;
      max_next   = (sample > bin_max) ? sample : bin_max;
    end
    closed_entry = {column_count, bin_first, bin_max, bin_min, bin_last, 1'b0};
    eor_entry    = {column_after, first_next, max_next, min_next, sample, 1'b1};
    if (pending) begin
      push      = ~queue_full;
      push_data = pending_entry;
    end else begin
      push      = accept & (close | emit_eor);
      push_data = close ? closed_entry : eor_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= '0;
      column_count  <= '0;
      next_boundary <= column_ratio(32'h0001_0000);
      bin_open      <= 1'b0;
      pending       <= 1'b0;
    end else begin
      if (pending && !queue_full) begin
        pending <= 1'b0;
      end
      if (accept) begin
        pending       <= close & emit_eor;
        pending_entry <= eor_entry;
        if (last) begin
          sample_count  <= '0;
          column_count  <= '0;
          next_boundary <= column_ratio(cfg.samples_per_column);
          bin_open      <= 1'b0;
        end else begin
          column_count <= column_after;
          if (close) begin
            next_boundary <= next_boundary + column_ratio(cfg.samples_per_column);
          end
          bin_open <= 1'b1;
          if (active_after) begin
            sample_count <= sample_count + 1'b1;
          end
        end
      end else if (ratio_wr.write && !bin_open) begin
        next_boundary <= column_ratio(ratio_wr.value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin_first <= first_next;
      bin_min   <= min_next;
      bin_max   <= max_next;
      bin_last  <= sample;
    end
  end

endmodule
`default_nettype wire

// ===== design/mmdec_queue.sv =====
// Short first-in first-out queue of closed columns between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module mmdec_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mmdec_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty
);
  localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]      slots [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_BITS-1:0] count;
  logic                  do_push, do_pop;

  assign full      = count == COUNT_BITS'(DEPTH);
  assign not_empty = count != '0;
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/mmdec_back.sv =====
// Back end: maps queued columns to screen coordinates in a three-stage pipeline.
`timescale 1ns / 1ps
`default_nettype none
module mmdec_back #(
  parameter int SAMPLE_BITS = mmdec_pkg::SAMPLE_BITS_DEF,
  parameter int COLUMN_BITS = mmdec_pkg::COLUMN_BITS_DEF,
  parameter int ENTRY_BITS  = COLUMN_BITS + 4 * SAMPLE_BITS + 1
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire mmdec_pkg::cfg_t                         cfg,
  input  wire logic                                    entry_valid,
  input  wire logic [ENTRY_BITS-1:0]                   entry_data,
  output logic                                         pop,
  output logic                                         column_valid,
  input  wire logic                                    column_stall,
  output logic signed [mmdec_pkg::X_BITS-1:0]          x,
  output logic signed [mmdec_pkg::Y_BITS-1:0]          y_first,
  output logic signed [mmdec_pkg::Y_BITS-1:0]          y_max,
  output logic signed [mmdec_pkg::Y_BITS-1:0]          y_min,
  output logic signed [mmdec_pkg::Y_BITS-1:0]          y_last,
  output logic                                         end_of_record
);
  import mmdec_pkg::*;

  localparam int DW  = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;
  localparam int PW  = DW + 25;
  localparam int QW  = ((PW - FRAC_BITS) > Y_BITS) ? PW - FRAC_BITS : Y_BITS;
  localparam int RND = (1 << FRAC_BITS) - 1;

  logic [COLUMN_BITS-1:0]        entry_column;
  logic signed [SAMPLE_BITS-1:0] entry_smp [4];
  logic                          entry_eor;

  logic                          vld1, vld2;
  logic signed [DW-1:0]          diff1 [4];
  logic signed [X_BITS-1:0]      x1, x2;
  logic                          eor1, eor2;
  logic signed [PW-1:0]          prod2 [4];
  logic                          adv1, adv2, adv3;

  logic signed [PW-1:0]          rounded [4];
  logic signed [QW-1:0]          ysum [4];

  assign entry_column = entry_data[ENTRY_BITS-1 -: COLUMN_BITS];
  assign entry_smp[0] = entry_data[1 + 4*SAMPLE_BITS - 1 -: SAMPLE_BITS];
  assign entry_smp[1] = entry_data[1 + 3*SAMPLE_BITS - 1 -: SAMPLE_BITS];
  assign entry_smp[2] = entry_data[1 + 2*SAMPLE_BITS - 1 -: SAMPLE_BITS];
  assign entry_smp[3] = entry_data[1 + SAMPLE_BITS - 1 -: SAMPLE_BITS];
  assign entry_eor    = entry_data[0];

  assign adv3 = ~column_valid | ~column_stall;
  assign adv2 = ~vld2 | adv3;
  assign adv1 = ~vld1 | adv2;
  assign pop  = entry_valid & adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1         <= 1'b0;
      vld2         <= 1'b0;
      column_valid <= 1'b0;
    end else begin
      if (adv1) begin
        vld1 <= entry_valid;
      end
      if (adv2) begin
        vld2 <= vld1;
      end
      if (adv3) begin
        column_valid <= vld2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && entry_valid) begin
      x1   <= X_BITS'(entry_column) + X_BITS'($signed(cfg.x_offset));
      eor1 <= entry_eor;
      for (int i = 0; i < 4; i++) begin
        diff1[i] <= DW'($signed(cfg.top_level))
                    - (DW'(entry_smp[i]) + DW'($signed(cfg.level_offset)));
      end
    end
    if (adv2 && vld1) begin
      x2   <= x1;
      eor2 <= eor1;
      for (int i = 0; i < 4; i++) begin
        prod2[i] <= diff1[i] * $signed({1'b0, cfg.pixels_per_code});
      end
    end
    if (adv3 && vld2) begin
      x             <= x2;
      end_of_record <= eor2;
      y_first       <= ysum[0][Y_BITS-1:0];
      y_max         <= ysum[1][Y_BITS-1:0];
      y_min         <= ysum[2][Y_BITS-1:0];
      y_last        <= ysum[3][Y_BITS-1:0];
    end
  end

  // The scaled product is truncated toward zero before the margin is added.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rounded[i] = prod2[i] + (prod2[i][PW-1] ? PW'(RND) : PW'(0));
      ysum[i]    = QW'($signed(rounded[i][PW-1:FRAC_BITS])) + QW'(cfg.top_margin);
    end
  end

endmodule
`default_nettype wire

// ===== design/waveform_min_max_decimator_core.sv =====
// Top level of the min/max waveform decimator with its configuration port.
`timescale 1ns / 1ps
`default_nettype none
// The core takes one sample per clock while sample_stall is low and cuts each record into
// display columns of samples_per_column (Q16.16) samples, reporting per column the screen
// rows of the first, largest, smallest and last sample. A column is reported when the first
// sample of the next column arrives or when the record's last sample arrives. The front end
// writes one queue entry per cycle, so a last sample that both closes a column and ends the
// record raises sample_stall while its second entry waits; every other sample is accepted
// while the four-entry queue has room. A column reaches the output through the queue and a
// three-stage mapping pipeline. Registers must be written by the user only while no
// transaction is in flight; the core does not enforce this.
module waveform_min_max_decimator_core #(
  parameter int SAMPLE_BITS = mmdec_pkg::SAMPLE_BITS_DEF,
  parameter int COLUMN_BITS = mmdec_pkg::COLUMN_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [mmdec_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  wire logic [mmdec_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic      [mmdec_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                      pready,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample,
  input  wire logic                                 last,
  input  wire logic                                 sample_valid,
  output logic                                      sample_stall,
  output logic signed [mmdec_pkg::X_BITS-1:0]       x,
  output logic signed [mmdec_pkg::Y_BITS-1:0]       y_first,
  output logic signed [mmdec_pkg::Y_BITS-1:0]       y_max,
  output logic signed [mmdec_pkg::Y_BITS-1:0]       y_min,
  output logic signed [mmdec_pkg::Y_BITS-1:0]       y_last,
  output logic                                      end_of_record,
  output logic                                      column_valid,
  input  wire logic                                 column_stall
);
  import mmdec_pkg::*;

  localparam int ENTRY_BITS = COLUMN_BITS + 4 * SAMPLE_BITS + 1;

  cfg_t                  cfg;
  ratio_write_t          ratio_wr;
  logic                  push, queue_full, pop, not_empty;
  logic [ENTRY_BITS-1:0] push_data, pop_data;

  mmdec_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .ratio_wr (ratio_wr)
  );

  mmdec_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .ratio_wr     (ratio_wr),
    .sample       (sample),
    .last         (last),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .queue_full   (queue_full),
    .push         (push),
    .push_data    (push_data)
  );

  mmdec_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  mmdec_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .entry_valid   (not_empty),
    .entry_data    (pop_data),
    .pop           (pop),
    .column_valid  (column_valid),
    .column_stall  (column_stall),
    .x             (x),
    .y_first       (y_first),
    .y_max         (y_max),
    .y_min         (y_min),
    .y_last        (y_last),
    .end_of_record (end_of_record)
  );

endmodule
`default_nettype wire

// ===== test/waveform_min_max_decimator_core_tb.sv =====
// Self-checking testbench for the min/max waveform decimator core.
`timescale 1ns / 1ps
module waveform_min_max_decimator_core_tb;
  import mmdec_pkg::*;

  localparam int TOTAL_SAMPLES  = 1900;
  localparam int SETTLE_CYCLES  = 12;
  localparam int DIRECTED_STEPS = 41;

  typedef struct packed {
    logic signed [X_BITS-1:0] x;
    logic signed [Y_BITS-1:0] y_first;
    logic signed [Y_BITS-1:0] y_max;
    logic signed [Y_BITS-1:0] y_min;
    logic signed [Y_BITS-1:0] y_last;
    logic                     eor;
  } column_t;

  typedef enum logic {
    STEP_SAMPLE = 1'b0,
    STEP_WRITE  = 1'b1
  } step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    reg_index_t  idx;
    logic [31:0] value;
    logic        last;
    logic        given;
    column_t     want;
  } step_t;

  localparam column_t NO_COLUMN = '0;

  // Rows with a typed column replace the newest expected column of that transaction.
  step_t directed_steps [DIRECTED_STEPS] = '{
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_0064, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_8000, 1'b0, 1'b1,
      '{14'sd0, -27'sd100, -27'sd100, -27'sd100, -27'sd100, 1'b0}},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_7FFF, 1'b0, 1'b1,
      '{14'sd1, 27'sd32768, 27'sd32768, 27'sd32768, 27'sd32768, 1'b0}},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_0000, 1'b0, 1'b1,
      '{14'sd2, -27'sd32767, -27'sd32767, -27'sd32767, -27'sd32767, 1'b0}},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_FFFF, 1'b1, 1'b1,
      '{14'sd4, 27'sd1, 27'sd1, 27'sd1, 27'sd1, 1'b1}},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_0005, 1'b1, 1'b1,
      '{14'sd0, -27'sd5, -27'sd5, -27'sd5, -27'sd5, 1'b1}},
    '{STEP_WRITE,  REG_SAMPLES_PER_COLUMN, 32'h0000_0000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_MAX_COLUMNS,        32'h0000_0000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_0007, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_FFF9, 1'b1, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_MAX_COLUMNS,        32'h0000_0002, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_SAMPLES_PER_COLUMN, 32'h0001_8000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_000A, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_FFEC, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_001E, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_0028, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_0032, 1'b1, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_SAMPLES_PER_COLUMN, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_TOP_LEVEL,          32'h0000_7FFF, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_LEVEL_OFFSET,       32'h0000_8000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_PIXELS_PER_CODE,    32'h00FF_FFFF, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_TOP_MARGIN,         32'h0000_0FFF, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_X_OFFSET,           32'h0000_0FFF, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_MAX_COLUMNS,        32'h0000_1FFF, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_8000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_7FFF, 1'b1, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_X_OFFSET,           32'h0000_1000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_TOP_LEVEL,          32'h0000_8000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_LEVEL_OFFSET,       32'h0000_7FFF, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_PIXELS_PER_CODE,    32'h0000_0000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_0000, 1'b1, 1'b1,
      '{-14'sd4096, 27'sd4095, 27'sd4095, 27'sd4095, 27'sd4095, 1'b1}},
    '{STEP_WRITE,  REG_SAMPLES_PER_COLUMN, 32'h0002_0000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_PIXELS_PER_CODE,    32'h0001_0000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_TOP_MARGIN,         32'h0000_0000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_X_OFFSET,           32'h0000_0000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_0001, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_0002, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_0003, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_WRITE,  REG_SAMPLES_PER_COLUMN, 32'h0001_0000, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_0004, 1'b0, 1'b0, NO_COLUMN},
    '{STEP_SAMPLE, REG_SAMPLES_PER_COLUMN, 32'h0000_0005, 1'b1, 1'b0, NO_COLUMN}
  };

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0]         paddr = '0;
  logic [CFG_DATA_BITS-1:0]         pwdata = '0;
  logic [CFG_DATA_BITS-1:0]         prdata;
  logic                             pready;
  logic signed [SAMPLE_BITS_DEF-1:0] sample = '0;
  logic                             last = 1'b0;
  logic                             sample_valid = 1'b0;
  logic                             sample_stall;
  logic signed [X_BITS-1:0]         x;
  logic signed [Y_BITS-1:0]         y_first;
  logic signed [Y_BITS-1:0]         y_max;
  logic signed [Y_BITS-1:0]         y_min;
  logic signed [Y_BITS-1:0]         y_last;
  logic                             end_of_record;
  logic                             column_valid;
  logic                             column_stall = 1'b0;

  logic    step_given = 1'b0;
  column_t step_want = '0;

  cfg_t               display_cfg;
  logic [31:0]        rec_index;
  logic [12:0]        col_index;
  logic [47:0]        col_end;
  logic signed [15:0] col_first;
  logic signed [15:0] col_low;
  logic signed [15:0] col_high;
  logic signed [15:0] col_latest;
  logic               col_open;
  column_t            pending_columns [$];

  int send_odds = 0;
  int sink_odds = 0;
  int error_count = 0;
  int samples_sent = 0;
  int columns_checked = 0;
  int phases = 0;

  waveform_min_max_decimator_core DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .sample(sample),
    .last(last),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .x(x),
    .y_first(y_first),
    .y_max(y_max),
    .y_min(y_min),
    .y_last(y_last),
    .end_of_record(end_of_record),
    .column_valid(column_valid),
    .column_stall(column_stall)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [47:0] column_step();
    if (display_cfg.samples_per_column < 32'h0001_0000) begin
      return 48'h0001_0000;
    end
    return {16'h0000, display_cfg.samples_per_column};
  endfunction

  task automatic restart_record();
    rec_index  = '0;
    col_index  = '0;
    col_end    = column_step();
    col_first  = '0;
    col_low    = '0;
    col_high   = '0;
    col_latest = '0;
    col_open   = 1'b0;
  endtask

  function automatic logic [Y_BITS-1:0] screen_row(input logic signed [15:0] v);
    longint diff;
    longint prod;
    longint row;
    diff = longint'($signed(display_cfg.top_level))
         - (longint'(v) + longint'($signed(display_cfg.level_offset)));
    prod = diff * longint'(display_cfg.pixels_per_code);
    row  = prod / 65536 + longint'(display_cfg.top_margin);
    return row[Y_BITS-1:0];
  endfunction

  function automatic column_t close_column(input logic eor);
    column_t c;
    c.x       = {1'b0, col_index} + {display_cfg.x_offset[12], display_cfg.x_offset};
    c.y_first = screen_row(col_first);
    c.y_max   = screen_row(col_high);
    c.y_min   = screen_row(col_low);
    c.y_last  = screen_row(col_latest);
    c.eor     = eor;
    return c;
  endfunction

  task automatic decimate_sample(input logic signed [15:0] v, input logic is_last);
    logic running;
    running = col_index < display_cfg.max_columns;
    if (col_open && running && {16'h0000, rec_index} >= (col_end >> 16)) begin
      pending_columns.push_back(close_column(1'b0));
      col_index = col_index + 13'd1;
      col_end   = col_end + column_step();
      col_open  = 1'b0;
      running   = col_index < display_cfg.max_columns;
    end
    if (!col_open) begin
      col_first = v;
      col_low   = v;
      col_high  = v;
      col_open  = 1'b1;
    end else if (v < col_low) begin
      col_low = v;
    end else if (v > col_high) begin
      col_high = v;
    end
    col_latest = v;
    if (running) begin
      rec_index = rec_index + 32'd1;
    end
    if (is_last) begin
      if (running) begin
        pending_columns.push_back(close_column(1'b1));
      end
      restart_record();
    end
  endtask

  task automatic check_field(input string name, input logic [Y_BITS-1:0] want,
                             input logic [Y_BITS-1:0] got);
    if (got !== want) begin
      report_error($sformatf("column %0d: %s is %0h, expected %0h",
                             columns_checked, name, got, want));
    end
  endtask

  task automatic check_column();
    column_t want;
    if (pending_columns.size() == 0) begin
      report_error($sformatf("column at x %0d arrived with none outstanding", x));
    end else begin
      want = pending_columns.pop_front();
      columns_checked++;
      check_field("x", Y_BITS'(want.x), Y_BITS'(x));
      check_field("y_first", want.y_first, y_first);
      check_field("y_max", want.y_max, y_max);
      check_field("y_min", want.y_min, y_min);
      check_field("y_last", want.y_last, y_last);
      check_field("end_of_record", Y_BITS'(want.eor), Y_BITS'(end_of_record));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (column_valid && !column_stall) begin
        check_column();
      end
      if (sample_valid && !sample_stall) begin
        decimate_sample(sample, last);
        if (step_given) begin
          void'(pending_columns.pop_back());
          pending_columns.push_back(step_want);
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (sink_odds != 0 && $urandom_range(1, 100) <= sink_odds) begin
        column_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        column_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SAMPLES_PER_COLUMN: begin
        display_cfg.samples_per_column = value;
        if (!col_open) begin
          col_end = column_step();
        end
      end
      REG_TOP_LEVEL:       display_cfg.top_level = value[15:0];
      REG_LEVEL_OFFSET:    display_cfg.level_offset = value[15:0];
      REG_PIXELS_PER_CODE: display_cfg.pixels_per_code = value[23:0];
      REG_TOP_MARGIN:      display_cfg.top_margin = value[11:0];
      REG_X_OFFSET:        display_cfg.x_offset = value[12:0];
      REG_MAX_COLUMNS:     display_cfg.max_columns = value[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [15:0] value, input logic is_last,
                             input logic given, input column_t want);
    if (send_odds != 0 && $urandom_range(1, 100) <= send_odds) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    sample       <= value;
    last         <= is_last;
    step_given   <= given;
    step_want    <= want;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    samples_sent++;
  endtask

  task automatic settle_idle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_odds(input int heavy);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return heavy;
    endcase
  endfunction

  initial begin
    logic        busy;
    logic        calm;
    logic [15:0] value;
    logic [31:0] ratio;
    logic [23:0] gain;
    logic [12:0] columns;
    int          phase_len;
    int          sent_in_phase;
    int          rec_len;
    int          pos;

    display_cfg = '{32'h0001_0000, 16'sd0, 16'sd0, 24'h01_0000, 12'd0, 13'sd0, 13'd1024};
    restart_record();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_odds = 20;
    sink_odds = 10;
    busy = 1'b0;
    for (int i = 0; i < DIRECTED_STEPS; i++) begin
      if (directed_steps[i].kind == STEP_WRITE) begin
        if (busy) begin
          settle_idle();
          busy = 1'b0;
        end
        write_reg(directed_steps[i].idx, directed_steps[i].value);
      end else begin
        send_sample(directed_steps[i].value[15:0], directed_steps[i].last,
                    directed_steps[i].given, directed_steps[i].want);
        busy = 1'b1;
      end
    end
    if (busy) begin
      settle_idle();
    end

    while (samples_sent < TOTAL_SAMPLES + DIRECTED_STEPS) begin
      phases++;
      calm = (samples_sent + 250 >= TOTAL_SAMPLES);
      send_odds = calm ? 0 : pick_odds(30);
      sink_odds = calm ? 0 : pick_odds(15);

      case ($urandom_range(0, 9))
        0:       ratio = $urandom_range(0, 32'h0000_FFFF);
        1:       ratio = $urandom;
        2:       ratio = 32'h0001_0000;
        default: ratio = $urandom_range(32'h0001_0000, 32'h0008_0000);
      endcase
      case ($urandom_range(0, 5))
        0:       gain = 24'h00_0000;
        1:       gain = 24'($urandom);
        default: gain = 24'($urandom_range(24'h00_4000, 24'h04_0000));
      endcase
      case ($urandom_range(0, 11))
        0:       columns = 13'd0;
        1, 2:    columns = 13'($urandom_range(1, 6));
        3:       columns = 13'($urandom_range(4097, 8191));
        default: columns = 13'($urandom_range(1, 4096));
      endcase
      write_reg(REG_SAMPLES_PER_COLUMN, ratio);
      write_reg(REG_TOP_LEVEL, {16'h0000, 16'($urandom)});
      write_reg(REG_LEVEL_OFFSET, {16'h0000, 16'($urandom)});
      write_reg(REG_PIXELS_PER_CODE, {8'h00, gain});
      write_reg(REG_TOP_MARGIN, 32'($urandom_range(0, 4095)));
      write_reg(REG_X_OFFSET, {19'h0, 13'($urandom)});
      write_reg(REG_MAX_COLUMNS, {19'h0, columns});

      // Records usually end inside the phase; the one cut off continues after the writes.
      phase_len = $urandom_range(40, 200);
      sent_in_phase = 0;
      while (sent_in_phase < phase_len) begin
        case ($urandom_range(0, 9))
          0:       rec_len = $urandom_range(1, 3);
          1:       rec_len = $urandom_range(100, 300);
          default: rec_len = $urandom_range(4, 40);
        endcase
        for (pos = 0; pos < rec_len && sent_in_phase < phase_len; pos++) begin
          case ($urandom_range(0, 7))
            0:       value = 16'h8000;
            1:       value = 16'h7FFF;
            2:       value = 16'($urandom_range(0, 15)) - 16'd8;
            default: value = 16'($urandom);
          endcase
          send_sample(value, pos == rec_len - 1, 1'b0, NO_COLUMN);
          sent_in_phase++;
        end
      end
      settle_idle();
    end

    if (pending_columns.size() != 0) begin
      report_error($sformatf("%0d columns never arrived", pending_columns.size()));
    end
    $display("Streamed %0d samples through %0d random register settings after the directed rows.",
             samples_sent, phases);
    $display("Compared %0d output columns, %0d mismatches.", columns_checked, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
